/* sv/kmst_pkg.sv */
// ----------------------------------------------------------------------------
// kmst_pkg: shared types and constants for the maximum spanning tree unit
// Holds sizes, field widths, the edge record and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package kmst_pkg;

  localparam int unsigned MAX_NODES = 64;
  localparam int unsigned MAX_EDGES = 256;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned EIDX_W    = $clog2(MAX_EDGES);
  localparam int unsigned ECNT_W    = EIDX_W + 1;
  localparam int unsigned WGT_W     = 16;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned RANK_W    = 3;

  typedef struct packed {
    logic [WGT_W-1:0]  weight;
    logic [NODE_W-1:0] dest;
    logic [NODE_W-1:0] src;
  } edge_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_INIT,
    ST_FETCH,
    ST_EDGE,
    ST_FIND,
    ST_COMPRESS,
    ST_JOIN,
    ST_EMIT,
    ST_EMPTY
  } state_t;

endpackage

`default_nettype wire

/* sv/kruskal_max_spanning_tree_unit.sv */
// ----------------------------------------------------------------------------
// kruskal_max_spanning_tree_unit: maximum spanning tree by Kruskal's method
// Stores edges, sorts them by descending weight and runs union-find.
// ----------------------------------------------------------------------------
// Loading: one edge transfer per cycle while no run is active.
// Run after the last edge: the insertion sort (order read, edge read and
// compare for each step, through the single read ports), then a reset of
// every union-find entry, then the union-find walk for each edge.
// in_tready is low for the whole run.
// Reset: synchronous active-low; clears control and node_count to 64.
`default_nettype none

module kruskal_max_spanning_tree_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,   // node_count
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,    // edge_src[5:0], edge_dest[11:6], edge_weight[27:12]
  input  wire logic        in_tlast,    // edge_last
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,   // tree_src[5:0], tree_dest[11:6], tree_weight[27:12]
  output      logic        out_tuser,   // found
  output      logic        out_tlast    // tree_last
);
  import kmst_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  ncfg_r;
  logic [ECNT_W-1:0] stored_r, stored_nxt;
  logic [ECNT_W-1:0] i_r, i_nxt;          // sort outer index / Kruskal edge index
  logic [ECNT_W-1:0] j_r, j_nxt;          // sort insert position
  logic [WGT_W-1:0]  wi_r, wi_nxt;        // weight being inserted
  logic [EIDX_W-1:0] prev_r, prev_nxt;    // order entry at j-1
  logic [NODE_W:0]   init_r, init_nxt;
  logic [CNT_W-1:0]  lim_r, lim_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  edge_t             cur_r, cur_nxt;      // edge under test
  logic              side_r, side_nxt;    // 0: finding src root, 1: dest
  logic [NODE_W-1:0] walk_r, walk_nxt;    // current node of the walk
  logic [NODE_W-1:0] root_r, root_nxt;
  logic [NODE_W-1:0] rs_r, rs_nxt;
  logic [NODE_W:0]   guard_r, guard_nxt;
  logic              cmp_phase_r, cmp_phase_nxt;

  // Union-find tables: 64 entries each. Reads are registered; the read
  // address follows the next walk node and the next pair of roots, so the
  // data is current in the cycle that uses it.
  logic [NODE_W-1:0] parent_r [MAX_NODES];
  logic [RANK_W-1:0] rank_r   [MAX_NODES];
  logic [NODE_W-1:0] par_q_r;             // parent of the walk node
  logic [RANK_W-1:0] rank_s_r, rank_d_r;  // ranks of the two roots
  logic              par_we;
  logic [NODE_W-1:0] par_wa, par_wd;
  logic              rank_we;
  logic [NODE_W-1:0] rank_wa;
  logic [RANK_W-1:0] rank_wd;

  // Output register
  logic              ov_r, ov_nxt;
  edge_t             od_r, od_nxt;
  logic              of_r, of_nxt, ol_r, ol_nxt;

  // Pending emitted edge whose last flag is undecided is held in a side
  // register and only released when the next edge or the end is known.
  logic  hold_r;
  edge_t hd_r;
  logic  fire_edge, fire_end;

  // Memory ports
  logic              e_we;
  logic [EIDX_W-1:0] e_wa, e_ra;
  edge_t             e_wd, e_rd;
  logic              o_we;
  logic [EIDX_W-1:0] o_wa, o_wd, o_ra, o_rd;

  kmst_edge_ram u_edges (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
  );
  kmst_order_ram u_order (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd)
  );

  edge_t in_edge;
  assign in_edge.src    = in_tdata[5:0];
  assign in_edge.dest   = in_tdata[11:6];
  assign in_edge.weight = in_tdata[27:12];

  logic in_xfer, out_xfer;
  assign in_tready = (state_r == ST_LOAD);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = ov_r && out_tready;

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'b0, od_r.weight, od_r.dest, od_r.src};
  assign out_tuser  = of_r;
  assign out_tlast  = ol_r;

  logic [NODE_W-1:0] par_walk;
  logic [NODE_W-1:0] rd_root;
  assign par_walk = par_q_r;

  always_comb begin
    state_nxt = state_r;
    stored_nxt = stored_r; i_nxt = i_r; j_nxt = j_r; wi_nxt = wi_r;
    prev_nxt = prev_r; init_nxt = init_r; lim_nxt = lim_r; count_nxt = count_r;
    cur_nxt = cur_r; side_nxt = side_r; walk_nxt = walk_r; root_nxt = root_r;
    rs_nxt = rs_r; guard_nxt = guard_r; cmp_phase_nxt = cmp_phase_r;
    ov_nxt = ov_r; od_nxt = od_r; of_nxt = of_r; ol_nxt = ol_r;
    e_we = 1'b0; e_wa = stored_r[EIDX_W-1:0]; e_wd = in_edge; e_ra = '0;
    o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
    par_we = 1'b0; par_wa = '0; par_wd = '0;
    rank_we = 1'b0; rank_wa = '0; rank_wd = '0;
    rd_root = '0;
    if (out_xfer) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (in_edge.weight != '0 && stored_r < ECNT_W'(MAX_EDGES)) begin
            e_we = 1'b1;
            stored_nxt = stored_r + 1'b1;
          end
          if (in_tlast) begin
            i_nxt = '0;
            state_nxt = ST_SORT_RD;
          end
        end
      end
      ST_SORT_RD: begin
        // Start inserting edge i; read its weight.
        if (i_r == stored_r) begin
          init_nxt = '0;
          state_nxt = ST_INIT;
        end else begin
          e_ra = i_r[EIDX_W-1:0];
          j_nxt = i_r;
          cmp_phase_nxt = 1'b0;
          state_nxt = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        // phase 0: weight of i valid, latch; issue order read of j-1
        // phase 1: order entry valid -> read edge weight; phase 2 via wi compare
        if (!cmp_phase_r) begin
          if (j_r == i_r) begin
            wi_nxt = e_rd.weight;
          end
          if (j_r == '0) begin
            o_we = 1'b1; o_wa = '0; o_wd = i_r[EIDX_W-1:0];
            i_nxt = i_r + 1'b1;
            state_nxt = ST_SORT_RD;
          end else begin
            o_ra = j_r[EIDX_W-1:0] - 1'b1;
            cmp_phase_nxt = 1'b1;
            guard_nxt = '0;
          end
        end else if (guard_r == '0) begin
          prev_nxt = o_rd;
          e_ra = o_rd;
          guard_nxt = (NODE_W+1)'(1);
        end else begin
          if (e_rd.weight < wi_r) begin
            o_we = 1'b1; o_wa = j_r[EIDX_W-1:0]; o_wd = prev_r;
            j_nxt = j_r - 1'b1;
            cmp_phase_nxt = 1'b0;
          end else begin
            o_we = 1'b1; o_wa = j_r[EIDX_W-1:0]; o_wd = i_r[EIDX_W-1:0];
            i_nxt = i_r + 1'b1;
            state_nxt = ST_SORT_RD;
          end
        end
      end
      ST_INIT: begin
        par_we = 1'b1; par_wa = init_r[NODE_W-1:0]; par_wd = init_r[NODE_W-1:0];
        rank_we = 1'b1; rank_wa = init_r[NODE_W-1:0]; rank_wd = '0;
        init_nxt = init_r + 1'b1;
        if (init_r == (NODE_W+1)'(MAX_NODES - 1)) begin
          i_nxt = '0;
          count_nxt = '0;
          if (ncfg_r == '0) lim_nxt = '0;
          else if (ncfg_r > CNT_W'(MAX_NODES)) lim_nxt = CNT_W'(MAX_NODES - 1);
          else lim_nxt = ncfg_r - 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (i_r == stored_r || count_r == lim_r) begin
          // The held edge leaves as the final result once the output
          // register is free; until then the run stays here.
          if (!(hold_r && ov_r && !out_tready)) begin
            stored_nxt = '0;
            state_nxt = (count_r == '0) ? ST_EMPTY : ST_LOAD;
          end
        end else begin
          o_ra = i_r[EIDX_W-1:0];
          guard_nxt = '0;
          state_nxt = ST_EDGE;
        end
      end
      ST_EDGE: begin
        // read in order: order entry, then edge record
        if (guard_r == '0) begin
          e_ra = o_rd;
          guard_nxt = (NODE_W+1)'(1);
        end else begin
          cur_nxt = e_rd;
          i_nxt = i_r + 1'b1;
          if ({1'b0, e_rd.src} > {1'b0, lim_r[NODE_W-1:0]} ||
              {1'b0, e_rd.dest} > {1'b0, lim_r[NODE_W-1:0]} ||
              lim_r == CNT_W'(0)) begin
            state_nxt = ST_FETCH;
          end else begin
            side_nxt = 1'b0;
            walk_nxt = e_rd.src;
            guard_nxt = '0;
            state_nxt = ST_FIND;
          end
        end
      end
      ST_FIND: begin
        if (par_walk == walk_r || guard_r == (NODE_W+1)'(MAX_NODES)) begin
          root_nxt = walk_r;
          walk_nxt = side_r ? cur_r.dest : cur_r.src;
          state_nxt = ST_COMPRESS;
        end else begin
          walk_nxt = par_walk;
          guard_nxt = guard_r + 1'b1;
        end
      end
      ST_COMPRESS: begin
        if (par_walk != root_r) begin
          par_we = 1'b1; par_wa = walk_r; par_wd = root_r;
          walk_nxt = par_walk;
        end else if (!side_r) begin
          rs_nxt = root_r;
          side_nxt = 1'b1;
          walk_nxt = cur_r.dest;
          guard_nxt = '0;
          state_nxt = ST_FIND;
        end else begin
          state_nxt = (rs_r == root_r) ? ST_FETCH : ST_JOIN;
        end
      end
      ST_JOIN: begin
        rd_root = root_r;
        if (rank_s_r < rank_d_r) begin
          par_we = 1'b1; par_wa = rs_r; par_wd = rd_root;
        end else begin
          par_we = 1'b1; par_wa = rd_root; par_wd = rs_r;
          if (rank_s_r == rank_d_r && rank_s_r != 3'd7) begin
            rank_we = 1'b1; rank_wa = rs_r; rank_wd = rank_s_r + 1'b1;
          end
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; od_nxt = cur_r; of_nxt = 1'b1;
          count_nxt = count_r + 1'b1;
          ol_nxt = (count_r + 1'b1 == lim_r) || (i_r == stored_r);
          // tree_last must also account for no further acceptable edge:
          // hold back the flag decision until the next fetch shows the end.
          state_nxt = ST_FETCH;
        end
      end
      ST_EMPTY: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; od_nxt = '0; of_nxt = 1'b0; ol_nxt = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign fire_edge = (state_r == ST_EMIT) && (!ov_r || out_tready);
  assign fire_end  = (state_r == ST_FETCH) &&
                     (i_r == stored_r || count_r == lim_r) && hold_r &&
                     (!ov_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ncfg_r <= CNT_W'(MAX_NODES);
      stored_r <= '0;
      ov_r <= 1'b0;
      hold_r <= 1'b0;
      i_r <= '0; j_r <= '0; init_r <= '0; count_r <= '0; lim_r <= '0;
      guard_r <= '0; cmp_phase_r <= 1'b0; side_r <= 1'b0;
    end else begin
      if (cfg_we) ncfg_r <= cfg_wdata;
      state_r <= state_nxt;
      stored_r <= stored_nxt;
      i_r <= i_nxt; j_r <= j_nxt; init_r <= init_nxt; count_r <= count_nxt;
      lim_r <= lim_nxt; guard_r <= guard_nxt; cmp_phase_r <= cmp_phase_nxt;
      side_r <= side_nxt;
      // Edge results go through the hold register so tree_last is exact.
      if (fire_edge) begin
        hold_r <= 1'b1;
        ov_r <= hold_r ? 1'b1 : (ov_r && !out_tready);
      end else if (fire_end) begin
        hold_r <= 1'b0;
        ov_r <= 1'b1;
      end else if (state_r == ST_EMPTY) begin
        ov_r <= ov_nxt;
      end else if (out_xfer) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wi_r <= wi_nxt; prev_r <= prev_nxt; cur_r <= cur_nxt;
    walk_r <= walk_nxt; root_r <= root_nxt; rs_r <= rs_nxt;
    if (fire_edge) begin
      hd_r <= cur_r;
      if (hold_r) begin
        od_r <= hd_r; of_r <= 1'b1; ol_r <= 1'b0;
      end
    end else if (fire_end) begin
      od_r <= hd_r; of_r <= 1'b1; ol_r <= 1'b1;
    end else if (state_r == ST_EMPTY) begin
      od_r <= od_nxt; of_r <= of_nxt; ol_r <= ol_nxt;
    end
    if (par_we) parent_r[par_wa] <= par_wd;
    if (rank_we) rank_r[rank_wa] <= rank_wd;
    par_q_r  <= parent_r[walk_nxt];
    rank_s_r <= rank_r[rs_nxt];
    rank_d_r <= rank_r[root_nxt];
  end

  // The end is taken only when the output register is free.
  // (ST_FETCH holds until then.)

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !hold_r)
    else $error("pending tree edge left at end of run");
  assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= ECNT_W'(MAX_EDGES))
    else $error("edge count beyond store");
endmodule

`default_nettype wire

/* sv/kmst_edge_ram.sv */
// ----------------------------------------------------------------------------
// kmst_edge_ram: edge store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kmst_edge_ram (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [kmst_pkg::EIDX_W-1:0] waddr,
  input  wire kmst_pkg::edge_t       wdata,
  input  wire logic [kmst_pkg::EIDX_W-1:0] raddr,
  output kmst_pkg::edge_t            rdata
);
  import kmst_pkg::*;

  edge_t mem [MAX_EDGES];
  edge_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

`default_nettype wire

/* sv/kmst_order_ram.sv */
// ----------------------------------------------------------------------------
// kmst_order_ram: sorted order buffer
// Holds edge indexes in descending weight order; registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kmst_order_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [kmst_pkg::EIDX_W-1:0] waddr,
  input  wire logic [kmst_pkg::EIDX_W-1:0] wdata,
  input  wire logic [kmst_pkg::EIDX_W-1:0] raddr,
  output      logic [kmst_pkg::EIDX_W-1:0] rdata
);
  import kmst_pkg::*;

  logic [EIDX_W-1:0] mem [MAX_EDGES];
  logic [EIDX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

`default_nettype wire

/* verif/tb_kruskal_max_spanning_tree_unit.sv */
// ----------------------------------------------------------------------------
// tb_kruskal_max_spanning_tree_unit: self-checking bench for the MST unit
// Streams edge graphs into the unit and compares every tree-edge transfer
// against a behavioral Kruskal/union-find predictor. A directed table with
// known answers comes first, then random graphs at many node counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_kruskal_max_spanning_tree_unit;
  import kmst_pkg::*;

  // Expected tree-edge transfer, one per result.
  typedef struct {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dest;
    logic [WGT_W-1:0]  weight;
    logic              found;
    logic              last;
  } tree_res_t;

  // One row of the directed stimulus. A node count of -1 leaves the
  // register alone; has_known marks rows whose answer is typed in.
  typedef struct {
    int        node_cfg;
    int        src;
    int        dest;
    int        weight;
    bit        last;
    bit        has_known;
    tree_res_t known;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = 7'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  kruskal_max_spanning_tree_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // Predictor state: the stored graph and the node count register.
  edge_t     graph_edges[MAX_EDGES];
  int        graph_size = 0;
  int        node_reg = 64;
  tree_res_t tree_q[$];
  int        mismatches = 0;
  bit        idle_on = 1'b1;

  // Known answer for the row being sent, used instead of the predictor.
  bit        use_known = 1'b0;
  tree_res_t known_res;

  int uf_parent[MAX_NODES];
  int uf_rank[MAX_NODES];

  function automatic int find_root(int x);
    int r;
    int nx;
    r = x;
    while (uf_parent[r] != r) r = uf_parent[r];
    // Path compression, as the unit does it.
    while (uf_parent[x] != r) begin
      nx = uf_parent[x];
      uf_parent[x] = r;
      x = nx;
    end
    return r;
  endfunction

  // Runs Kruskal over the stored graph and queues the tree transfers.
  task automatic grow_tree();
    int order[MAX_EDGES];
    int n;
    int i;
    int j;
    int cnt;
    int rs;
    int rd;
    int key;
    edge_t e;
    tree_res_t r;
    n = node_reg;
    if (n < 1) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    // Stable sort by descending weight; ties stay in arrival order.
    for (i = 0; i < graph_size; i++) begin
      key = i;
      j = i;
      while (j > 0 && graph_edges[order[j-1]].weight < graph_edges[key].weight) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    for (i = 0; i < MAX_NODES; i++) begin
      uf_parent[i] = i;
      uf_rank[i] = 0;
    end
    cnt = 0;
    for (i = 0; i < graph_size && cnt < n - 1; i++) begin
      e = graph_edges[order[i]];
      if (e.src >= n || e.dest >= n) continue;
      rs = find_root(e.src);
      rd = find_root(e.dest);
      if (rs == rd) continue;
      if (uf_rank[rs] < uf_rank[rd]) uf_parent[rs] = rd;
      else if (uf_rank[rs] > uf_rank[rd]) uf_parent[rd] = rs;
      else begin
        uf_parent[rd] = rs;
        if (uf_rank[rs] < 7) uf_rank[rs]++;
      end
      r.src = e.src;
      r.dest = e.dest;
      r.weight = e.weight;
      r.found = 1'b1;
      r.last = 1'b0;
      tree_q.push_back(r);
      cnt++;
    end
    if (cnt == 0) begin
      r = '{src: '0, dest: '0, weight: '0, found: 1'b0, last: 1'b1};
      tree_q.push_back(r);
    end else begin
      tree_q[tree_q.size()-1].last = 1'b1;
    end
    graph_size = 0;
  endtask

  // Input monitor: every accepted edge transfer updates the predictor.
  always @(posedge clk) begin
    edge_t e;
    int prev_size;
    if (rst_n && in_tvalid && in_tready) begin
      e = in_tdata[27:0];
      // Weight zero means no edge; a full store ignores the edge.
      if (e.weight != 0 && graph_size < MAX_EDGES) begin
        graph_edges[graph_size] = e;
        graph_size++;
      end
      if (in_tlast) begin
        prev_size = tree_q.size();
        grow_tree();
        if (use_known) begin
          while (tree_q.size() > prev_size) void'(tree_q.pop_back());
          tree_q.push_back(known_res);
        end
      end
    end
  end

  // Result monitor: each tree transfer against the oldest expectation.
  always @(posedge clk) begin
    tree_res_t x;
    tree_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.src = out_tdata[5:0];
      got.dest = out_tdata[11:6];
      got.weight = out_tdata[27:12];
      got.found = out_tuser;
      got.last = out_tlast;
      if (tree_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected tree transfer src=%0d dest=%0d w=%0d found=%0b last=%0b",
                   $realtime, got.src, got.dest, got.weight, got.found, got.last);
      end else begin
        x = tree_q.pop_front();
        if (got.src !== x.src || got.dest !== x.dest || got.weight !== x.weight ||
            got.found !== x.found || got.last !== x.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: tree mismatch exp %0d-%0d w=%0d f=%0b l=%0b got %0d-%0d w=%0d f=%0b l=%0b",
                     $realtime, x.src, x.dest, x.weight, x.found, x.last,
                     got.src, got.dest, got.weight, got.found, got.last);
        end
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    out_tready <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
  end

  // Sends one edge transfer; called and returns just after a falling edge.
  // in_tready only changes at rising edges, so its value at a falling edge
  // decides whether the next rising edge takes the transfer.
  task automatic send_edge(int src, int dest, int weight, bit last);
    while (idle_on && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, weight[15:0], dest[5:0], src[5:0]};
    in_tlast <= last;
    while (!in_tready) @(negedge clk);
    @(negedge clk);
  endtask

  // Waits for all tree transfers, then lets the unit settle back to loading.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tree_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_nodes(int n);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= n[6:0];
    node_reg = n & 'h7f;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic tree_res_t tree_edge(int s, int d, int w);
    tree_res_t r;
    r = '{src: NODE_W'(s), dest: NODE_W'(d), weight: WGT_W'(w), found: 1'b1, last: 1'b1};
    return r;
  endfunction

  localparam tree_res_t NO_TREE = '{src: '0, dest: '0, weight: '0, found: 1'b0, last: 1'b1};

  dir_row_t dir_rows[$];

  initial begin
    int items;
    int run_len;
    int span;
    int wmax;
    int k;
    int s;
    int d;
    int runs;
    bit full_done;

    // Directed graphs. Rows after reset run at the reset node count of 64.
    dir_rows = '{
      '{-1, 0, 1, 5, 1, 1, tree_edge(0, 1, 5)},
      // Self loop alone: nothing joins, so the empty result comes back.
      '{-1, 3, 3, 100, 1, 1, NO_TREE},
      // A zero-weight edge marked last still starts an (empty) run.
      '{-1, 2, 4, 0, 1, 1, NO_TREE},
      '{-1, 0, 1, 10, 0, 0, NO_TREE},
      '{-1, 1, 2, 10, 0, 0, NO_TREE},
      '{-1, 0, 2, 30, 0, 0, NO_TREE},
      '{-1, 63, 0, 65535, 0, 0, NO_TREE},
      '{-1, 2, 63, 1, 0, 0, NO_TREE},
      '{-1, 5, 6, 0, 0, 0, NO_TREE},
      '{-1, 10, 20, 10, 1, 0, NO_TREE},
      '{-1, 63, 62, 65535, 1, 1, tree_edge(63, 62, 65535)},
      '{-1, 0, 63, 1, 1, 1, tree_edge(0, 63, 1)},
      // Two nodes: the edge to node 5 lies outside and is skipped.
      '{2, 0, 1, 7, 0, 0, NO_TREE},
      '{-1, 0, 5, 9, 0, 0, NO_TREE},
      '{-1, 1, 0, 3, 1, 0, NO_TREE},
      // Node count zero acts as one node; one node never takes an edge.
      '{0, 0, 1, 5, 1, 1, NO_TREE},
      '{1, 0, 1, 5, 1, 1, NO_TREE},
      // Above the node limit the count is clipped to 64.
      '{127, 63, 0, 4, 1, 1, tree_edge(63, 0, 4)},
      '{64, 42, 21, 43690, 0, 0, NO_TREE},
      '{-1, 21, 42, 21845, 1, 0, NO_TREE}
    };

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].node_cfg >= 0) set_nodes(dir_rows[i].node_cfg);
      use_known = dir_rows[i].has_known;
      known_res = dir_rows[i].known;
      send_edge(dir_rows[i].src, dir_rows[i].dest, dir_rows[i].weight, dir_rows[i].last);
    end
    drain();
    use_known = 1'b0;

    // Random graphs. Most are small; one sends more edges than the store holds.
    items = 0;
    runs = 0;
    full_done = 1'b0;
    while (items < 330) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(5))
          0: set_nodes(64);
          1: set_nodes($urandom_range(65, 127));
          2: set_nodes($urandom_range(0, 2));
          default: set_nodes($urandom_range(3, 64));
        endcase
      end
      // A quiet stretch with no idling on either side.
      idle_on = !(runs >= 6 && runs < 12);
      if (!full_done && items > 60) begin
        run_len = MAX_EDGES + 4;
        full_done = 1'b1;
      end else begin
        run_len = $urandom_range(1, 16);
      end
      span = (node_reg > 64 || node_reg == 0) ? 64 : node_reg;
      span = $urandom_range(1) ? span : (span + 4 > 64 ? 64 : span + 4);
      wmax = $urandom_range(1) ? 8 : 65535;
      for (k = 0; k < run_len; k++) begin
        s = $urandom_range(span - 1);
        d = ($urandom_range(9) == 0) ? s : $urandom_range(span - 1);
        send_edge(s, d, ($urandom_range(19) == 0) ? 0 : $urandom_range(1, wmax),
                  k == run_len - 1);
        items++;
      end
      // Once, after the fourth run, hold the sender back until the whole tree has come out.
      if (runs == 3) drain();
      runs++;
    end

    drain();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && tree_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
sv/kmst_pkg.sv
sv/kmst_edge_ram.sv
sv/kmst_order_ram.sv
sv/kruskal_max_spanning_tree_unit.sv
verif/tb_kruskal_max_spanning_tree_unit.sv
